// ----- hw/rtl/cbkl_pkg.sv -----
// Shared types and codes for the chained bucket key lookup walker.
// Depends on nothing; used by chained_bucket_key_lookup.
package cbkl_pkg;

    // Field widths fixed by the item formats
    localparam int KEY_W    = 64;
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 16;
    localparam int CNT32_W  = 32;
    localparam int KIND_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FOUND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;

    // Input commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SLOT   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key_id;
        logic [KEY_W-1:0]  slot_key;
        logic [ADDR_W-1:0] slot_value_offset;
        logic [LEN_W-1:0]  slot_value_size;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_out_item;

endpackage

// ----- hw/rtl/chained_bucket_key_lookup.sv -----
// Top level of the chained bucket key lookup walker.
// Depends on cbkl_pkg for item types, result kinds and register indexes.
//
// Usage:
//   Command channel: an item is taken at a clock edge with i_start high and
//   o_busy low. A lookup item (cmd 0) carries the key; slot items (cmd 1)
//   deliver the slots of the last requested bucket, link slot last.
//   Result channel: o_strobe marks one cycle holding o_result (bucket read
//   request, found with value address and size, or not found). The receiver
//   cannot stall; each result is shown for exactly one cycle.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Sequence:
//   A lookup gets its home bucket remainder from a restoring divider that
//   retires one key bit per cycle, then passes the shared address multiplier
//   and the final add. A slot item that needs an address goes through the
//   slot check, the multiplier and the final add; one that gives not found
//   skips the multiplier, and one with no result ends after the slot check.
//   o_busy is high throughout, so the block handles one item at a time.
// Reset:
//   Synchronous, active low. Clears the walk state and sets the registers
//   to region offset 0, slot count 0, bucket count 1.
module chained_bucket_key_lookup #(
    parameter int WAYS       = 8,
    parameter int SLOT_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_start,
    output logic                                o_busy,
    input  cbkl_pkg::t_in_item                  i_item,
    // result channel
    output logic                                o_strobe,
    output cbkl_pkg::t_out_item                 o_result,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbkl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cbkl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SPAN   = WAYS * SLOT_BYTES;
    localparam int K_W    = $clog2(SPAN + 1);
    localparam int POS_W  = $clog2(WAYS);
    localparam int CNT_W  = $clog2(cbkl_pkg::KEY_W);
    localparam int ADDR_W = cbkl_pkg::ADDR_W;
    localparam int C32_W  = cbkl_pkg::CNT32_W;

    localparam logic [K_W-1:0]   K_SPAN  = K_W'(SPAN);
    localparam logic [K_W-1:0]   K_SLOT  = K_W'(SLOT_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WAYS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cbkl_pkg::KEY_W - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SLOT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // control state
    logic [2:0]       r_state, n_state;
    logic             r_walk, n_walk;
    logic             r_skip, n_skip;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;

    // configuration registers
    logic [ADDR_W-1:0] r_region;
    logic [C32_W-1:0]  r_slot_count;
    logic [C32_W-1:0]  r_bucket_count;

    // payload registers
    logic [cbkl_pkg::KEY_W-1:0]  r_sought, n_sought;
    cbkl_pkg::t_in_item          r_item, n_item;
    logic [cbkl_pkg::KEY_W-1:0]  r_div_key, n_div_key;
    logic [C32_W-1:0]            r_rem, n_rem;
    logic [ADDR_W-1:0]           r_mul_a, n_mul_a;
    logic [K_W-1:0]              r_mul_k, n_mul_k;
    logic [ADDR_W-1:0]           r_prod, n_prod;
    logic [ADDR_W-1:0]           r_voff, n_voff;
    logic [cbkl_pkg::LEN_W-1:0]  r_len, n_len;
    logic [cbkl_pkg::KIND_W-1:0] r_kind, n_kind;
    cbkl_pkg::t_out_item         r_result, n_result;

    // divider step and address sum
    logic [C32_W:0]    div_trial;
    logic [C32_W:0]    div_diff;
    logic [C32_W-1:0]  div_rem;
    logic [ADDR_W-1:0] addr_sum;
    logic              slot_last;
    logic              accept;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    // one restoring division step: shift in next key bit, subtract if it fits
    assign div_trial = {r_rem, r_div_key[cbkl_pkg::KEY_W-1]};
    assign div_diff  = div_trial - {1'b0, r_bucket_count};
    assign div_rem   = (div_trial >= {1'b0, r_bucket_count}) ? div_diff[C32_W-1:0]
                                                             : div_trial[C32_W-1:0];

    assign addr_sum  = r_region + r_prod + r_voff;
    assign slot_last = (r_pos == POS_LAST);

    // next-state logic
    always_comb begin
        n_state   = r_state;
        n_walk    = r_walk;
        n_skip    = r_skip;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_sought  = r_sought;
        n_item    = r_item;
        n_div_key = r_div_key;
        n_rem     = r_rem;
        n_mul_a   = r_mul_a;
        n_mul_k   = r_mul_k;
        n_prod    = r_prod;
        n_voff    = r_voff;
        n_len     = r_len;
        n_kind    = r_kind;
        n_result  = r_result;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    if (i_item.cmd == cbkl_pkg::CMD_LOOKUP) begin
                        // new lookup abandons any walk in progress
                        n_sought  = i_item.key_id;
                        n_div_key = i_item.key_id;
                        n_rem     = '0;
                        n_cnt     = '0;
                        n_pos     = '0;
                        n_walk    = 1'b1;
                        n_skip    = 1'b0;
                        n_state   = ST_DIV;
                    end else if (r_walk) begin
                        n_state = ST_SLOT;
                    end
                end
            end

            ST_DIV: begin
                n_rem     = div_rem;
                n_div_key = {r_div_key[cbkl_pkg::KEY_W-2:0], 1'b0};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    // zero bucket count maps every key to bucket 0
                    n_mul_a = (r_bucket_count == '0) ? '0 : ADDR_W'(div_rem);
                    n_mul_k = K_SPAN;
                    n_voff  = '0;
                    n_len   = cbkl_pkg::LEN_W'(SPAN);
                    n_kind  = cbkl_pkg::KIND_READ;
                    n_state = ST_MUL;
                end
            end

            ST_SLOT: begin
                n_state = ST_IDLE;
                if (r_skip) begin
                    // draining after a match; link slot ends the walk
                    if (slot_last) begin
                        n_walk = 1'b0;
                        n_skip = 1'b0;
                        n_pos  = '0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end else if (!slot_last) begin
                    n_pos = r_pos + 1'b1;
                    if (r_item.slot_key == r_sought) begin
                        n_skip = 1'b1;
                        if (r_sought == '0) begin
                            n_kind  = cbkl_pkg::KIND_MISS;
                            n_state = ST_EMIT;
                        end else begin
                            n_mul_a = ADDR_W'(r_slot_count);
                            n_mul_k = K_SLOT;
                            n_voff  = r_item.slot_value_offset;
                            n_len   = r_item.slot_value_size;
                            n_kind  = cbkl_pkg::KIND_FOUND;
                            n_state = ST_MUL;
                        end
                    end
                end else begin
                    // link slot: end of chain or next bucket
                    n_pos = '0;
                    if (r_item.slot_key == '0) begin
                        n_walk  = 1'b0;
                        n_kind  = cbkl_pkg::KIND_MISS;
                        n_state = ST_EMIT;
                    end else begin
                        n_mul_a = r_item.slot_key[ADDR_W-1:0];
                        n_mul_k = K_SPAN;
                        n_voff  = '0;
                        n_len   = cbkl_pkg::LEN_W'(SPAN);
                        n_kind  = cbkl_pkg::KIND_READ;
                        n_state = ST_MUL;
                    end
                end
            end

            // shared address multiplier, low bits only since addresses wrap
            ST_MUL: begin
                n_prod  = ADDR_W'(r_mul_a * ADDR_W'(r_mul_k));
                n_state = ST_EMIT;
            end

            ST_EMIT: begin
                n_strobe             = 1'b1;
                n_result.result_kind = r_kind;
                if (r_kind == cbkl_pkg::KIND_MISS) begin
                    n_result.address = '0;
                    n_result.length  = '0;
                end else begin
                    n_result.address = addr_sum;
                    n_result.length  = r_len;
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_walk   <= 1'b0;
            r_skip   <= 1'b0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_sought <= '0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_skip   <= n_skip;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            r_sought <= n_sought;
        end
    end

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region       <= '0;
            r_slot_count   <= '0;
            r_bucket_count <= C32_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbkl_pkg::CFG_REGION_OFFSET: r_region       <= i_cfg_data[ADDR_W-1:0];
                cbkl_pkg::CFG_SLOT_COUNT:    r_slot_count   <= i_cfg_data[C32_W-1:0];
                cbkl_pkg::CFG_BUCKET_COUNT:  r_bucket_count <= i_cfg_data[C32_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_div_key <= n_div_key;
        r_rem     <= n_rem;
        r_mul_a   <= n_mul_a;
        r_mul_k   <= n_mul_k;
        r_prod    <= n_prod;
        r_voff    <= n_voff;
        r_len     <= n_len;
        r_kind    <= n_kind;
        r_result  <= n_result;
    end

endmodule
